/* hdl/status_led_breathe_engine_macros.svh */
// Assertion helpers shared by the RTL. Clock and reset are clk and rst_n.
`ifndef STATUS_LED_BREATHE_ENGINE_MACROS_SVH
`define STATUS_LED_BREATHE_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define SLBE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slbe assertion failed");

// antecedent implies consequent in the next cycle
`define SLBE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slbe assertion failed");

`else

`define SLBE_ASSERT_SAME(label, ante, cons)
`define SLBE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* hdl/slbe_pkg.sv */
`default_nettype none

package slbe_pkg;

    localparam int MODE_W     = 2;
    localparam int ELAPSED_W  = 14;
    localparam int CODE_W     = 3;
    localparam int AGENT_W    = 2;
    localparam int CHAN_W     = 8;
    localparam int COLOUR_W   = 24;
    localparam int PERIOD_W   = 12;
    localparam int RANK_W     = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int DIV_DVS_W  = 16;
    localparam int DIV_CNT_W  = 6;

    localparam logic [CHAN_W-1:0]    FULL_SCALE    = 8'hFF;
    localparam logic [DIV_DVS_W-1:0] LEVEL_DIVISOR = 16'd65025;

    localparam logic [COLOUR_W-1:0] COLOUR_AGENT0  = 24'hD97757;
    localparam logic [COLOUR_W-1:0] COLOUR_AGENT1  = 24'h4FA8C7;
    localparam logic [COLOUR_W-1:0] COLOUR_AGENT2  = 24'h8B7FD9;
    localparam logic [COLOUR_W-1:0] COLOUR_WAITING = 24'hE6961E;
    localparam logic [COLOUR_W-1:0] COLOUR_ERROR   = 24'hD9564F;
    localparam logic [COLOUR_W-1:0] COLOUR_DONE    = 24'h5FA85F;

    typedef enum logic [MODE_W-1:0] {
        REQ_TICK       = 2'd0,
        REQ_SESSION    = 2'd1,
        REQ_DISCONNECT = 2'd2,
        REQ_UNUSED     = 2'd3
    } req_mode_t;

    typedef enum logic [CODE_W-1:0] {
        SC_SLEEPING  = 3'd0,
        SC_IDLE      = 3'd1,
        SC_WORKING   = 3'd2,
        SC_CELEBRATE = 3'd3,
        SC_WAITING   = 3'd4,
        SC_ERROR     = 3'd5
    } state_code_t;

    typedef enum logic [1:0] {
        LM_OFF     = 2'd0,
        LM_STEADY  = 2'd1,
        LM_BREATHE = 2'd2,
        LM_PULSE   = 2'd3
    } light_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CEILING = 3'd0,
        CFG_FLOOR   = 3'd1,
        CFG_ERROR   = 3'd2,
        CFG_WAITING = 3'd3,
        CFG_WORKING = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_PHASE,
        FS_WAVE,
        FS_SCALE,
        FS_MUL,
        FS_LEVEL,
        FS_OUT
    } fsm_state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] iters;
    } sdiv_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sdiv_stat_t;

    function automatic logic [RANK_W-1:0] rank_of(input logic [CODE_W-1:0] code);
        logic [RANK_W-1:0] r;
        unique case (code)
            SC_ERROR:    r = 6'd40;
            SC_WAITING:  r = 6'd30;
            SC_CELEBRATE: r = 6'd15;
            SC_IDLE:     r = 6'd5;
            SC_SLEEPING: r = 6'd0;
            default:     r = 6'd20;
        endcase
        return r;
    endfunction

    function automatic logic [COLOUR_W-1:0] agent_colour(input logic [AGENT_W-1:0] ag);
        logic [COLOUR_W-1:0] c;
        unique case (ag)
            2'd1:    c = COLOUR_AGENT1;
            2'd2:    c = COLOUR_AGENT2;
            default: c = COLOUR_AGENT0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* hdl/slbe_req_if.sv */
`default_nettype none

interface slbe_req_if import slbe_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [MODE_W-1:0]    mode;
    logic [ELAPSED_W-1:0] delta_ms;
    logic [CODE_W-1:0]    state_code;
    logic [AGENT_W-1:0]   agent;
    logic                 last_session;

    modport source (
        output valid, mode, delta_ms, state_code, agent, last_session,
        input  ready
    );

    modport sink (
        input  valid, mode, delta_ms, state_code, agent, last_session,
        output ready
    );
endinterface

`default_nettype wire

/* hdl/slbe_duty_if.sv */
`default_nettype none

interface slbe_duty_if import slbe_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] duty_red;
    logic [CHAN_W-1:0] duty_green;
    logic [CHAN_W-1:0] duty_blue;

    modport source (
        output valid, duty_red, duty_green, duty_blue,
        input  ready
    );

    modport sink (
        input  valid, duty_red, duty_green, duty_blue,
        output ready
    );
endinterface

`default_nettype wire

/* hdl/slbe_sdiv.sv */
`default_nettype none
`include "status_led_breathe_engine_macros.svh"

// Bit-serial restoring divider, one quotient bit per cycle.
// Dividend bits leave qd_reg at the MSB into the remainder; quotient bits shift in at the LSB.
module slbe_sdiv import slbe_pkg::*; #(
    parameter int DVD_W = 30
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sdiv_ctl_t            ctl,
    input  wire logic [DIV_DVS_W-1:0] rem_init,
    input  wire logic [DVD_W-1:0]     dividend,
    input  wire logic [DIV_DVS_W-1:0] divisor,
    output sdiv_stat_t                stat,
    output logic [DVD_W-1:0]          quotient
);

    logic [DIV_DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0]     qd_reg, qd_next;
    logic [DIV_DVS_W-1:0] dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;

    logic [DIV_DVS_W:0] trial;
    logic [DIV_DVS_W:0] diff;
    logic               take;

    assign trial = {rem_reg, qd_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign take  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        qd_next   = qd_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            rem_next = rem_init;
            qd_next  = dividend;
            dvs_next = divisor;
            cnt_next = ctl.iters;
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = take ? diff[DIV_DVS_W-1:0] : trial[DIV_DVS_W-1:0];
            qd_next   = {qd_reg[DVD_W-2:0], take};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        qd_reg  <= qd_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign quotient  = qd_reg;

    `SLBE_ASSERT_SAME(a_rem_below_divisor, cnt_reg != '0, rem_reg < dvs_reg)
    `SLBE_ASSERT_SAME(a_done_when_drained, done_reg, cnt_reg == '0)
    `SLBE_ASSERT_NEXT(a_done_single, done_reg && !ctl.start, !done_reg)

endmodule

`default_nettype wire

/* hdl/status_led_breathe_engine.sv */
`default_nettype none
`include "status_led_breathe_engine_macros.svh"

// Channel    Dir   Handshake        Payload
// request    in    valid/ready      mode, delta_ms, state_code, agent, last_session
// duty       out   valid/ready      duty_red, duty_green, duty_blue
// cfg        in    cfg_we           cfg_index, cfg_data (write only)
//
// A session entry keeps the sequencer idle; a disconnect or a dark last entry goes to FS_OUT.
// A tick on a pulse or breathe light runs the phase step through the bit-serial divider one
// bit a cycle, then the wave lookup and scale, then each of the three channels in turn (start,
// serial divide by 65025, write-back). A steady tick skips the phase step and wave lookup.
// rst_n clears control state and loads the register defaults; no clearing pass.
// request.ready is high in the idle state; a finished result waits in the output
// register while the next transaction is accepted.
module status_led_breathe_engine import slbe_pkg::*; #(
    parameter int PHASE_BITS       = 16,
    parameter int WAVE_TABLE_DEPTH = 256
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    slbe_req_if.sink                   request,
    slbe_duty_if.source                duty
);

    localparam int IDX_W = $clog2(WAVE_TABLE_DEPTH);
    localparam int DVD_W = ELAPSED_W + PHASE_BITS;
    localparam int MUL_W = PHASE_BITS + IDX_W + 1;
    localparam longint DL = longint'(WAVE_TABLE_DEPTH);

    // raised-cosine table, built at elaboration
    logic [CHAN_W-1:0] wave_rom [WAVE_TABLE_DEPTH];

    for (genvar n = 0; n < WAVE_TABLE_DEPTH; n++)
    begin : g_wave
        localparam longint A   = longint'(n) * (DL - longint'(n));
        localparam longint NUM = 16 * A;
        localparam longint DEN = 5 * DL * DL - 4 * A;
        localparam longint DD  = DEN * DEN;
        localparam longint W   = (255 * NUM * NUM + DD / 2) / DD;
        assign wave_rom[n] = CHAN_W'(W);
    end

    logic [CHAN_W-1:0]   ceil_reg;
    logic [CHAN_W-1:0]   floor_reg;
    logic [PERIOD_W-1:0] err_per_reg;
    logic [PERIOD_W-1:0] wait_per_reg;
    logic [PERIOD_W-1:0] work_per_reg;

    fsm_state_t            fsm_reg, fsm_next;
    light_mode_t           light_mode_reg, light_mode_next;
    logic [COLOUR_W-1:0]   colour_reg, colour_next;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic [PERIOD_W-1:0]   period_reg, period_next;
    logic                  scan_found_reg, scan_found_next;
    logic [RANK_W-1:0]     scan_rank_reg, scan_rank_next;
    logic [CODE_W-1:0]     scan_state_reg, scan_state_next;
    logic [AGENT_W-1:0]    scan_agent_reg, scan_agent_next;
    logic [CHAN_W-1:0]     wave_reg, wave_next;
    logic [15:0]           scale_reg, scale_next;
    logic [1:0]            ch_reg, ch_next;
    logic [CHAN_W-1:0]     lvl_reg [3];
    logic [CHAN_W-1:0]     lvl_next [3];
    logic                  out_valid_reg, out_valid_next;
    logic [CHAN_W-1:0]     out_red_reg, out_red_next;
    logic [CHAN_W-1:0]     out_green_reg, out_green_next;
    logic [CHAN_W-1:0]     out_blue_reg, out_blue_next;

    sdiv_ctl_t            div_ctl;
    sdiv_stat_t           div_stat;
    logic [DIV_DVS_W-1:0] div_rem_init;
    logic [DVD_W-1:0]     div_dividend;
    logic [DIV_DVS_W-1:0] div_divisor;
    logic [DVD_W-1:0]     div_q;

    slbe_sdiv #(
        .DVD_W (DVD_W)
    ) u_sdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .rem_init (div_rem_init),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_q)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ceil_reg     <= 8'd90;
            floor_reg    <= 8'd12;
            err_per_reg  <= 12'd700;
            wait_per_reg <= 12'd1400;
            work_per_reg <= 12'd3200;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CEILING: ceil_reg     <= cfg_data[CHAN_W-1:0];
                CFG_FLOOR:   floor_reg    <= cfg_data[CHAN_W-1:0];
                CFG_ERROR:   err_per_reg  <= cfg_data[PERIOD_W-1:0];
                CFG_WAITING: wait_per_reg <= cfg_data[PERIOD_W-1:0];
                CFG_WORKING: work_per_reg <= cfg_data[PERIOD_W-1:0];
                default:     ;
            endcase
        end
    end

    // session scan and winner decode
    logic                accept;
    logic [RANK_W-1:0]   rank_new;
    logic                take;
    logic [CODE_W-1:0]   win_state;
    logic [AGENT_W-1:0]  win_agent;
    light_mode_t         win_mode;
    logic [COLOUR_W-1:0] win_colour;
    logic [PERIOD_W-1:0] win_period;

    assign accept    = request.valid && request.ready;
    assign rank_new  = rank_of(request.state_code);
    assign take      = !scan_found_reg || (rank_new > scan_rank_reg);
    assign win_state = take ? request.state_code : scan_state_reg;
    assign win_agent = take ? request.agent : scan_agent_reg;

    always_comb
    begin
        unique case (win_state)
            SC_ERROR:
            begin
                win_mode   = LM_PULSE;
                win_colour = COLOUR_ERROR;
                win_period = err_per_reg;
            end
            SC_WAITING:
            begin
                win_mode   = LM_PULSE;
                win_colour = COLOUR_WAITING;
                win_period = wait_per_reg;
            end
            SC_CELEBRATE:
            begin
                win_mode   = LM_STEADY;
                win_colour = COLOUR_DONE;
                win_period = '0;
            end
            SC_IDLE, SC_SLEEPING:
            begin
                win_mode   = LM_OFF;
                win_colour = '0;
                win_period = '0;
            end
            default:
            begin
                win_mode   = LM_BREATHE;
                win_colour = agent_colour(win_agent);
                win_period = work_per_reg;
            end
        endcase
    end

    // datapath helpers
    logic [MUL_W-1:0]          idx_full;
    logic [IDX_W-1:0]          wave_idx;
    logic signed [8:0]         span;
    logic signed [17:0]        span_wave;
    logic [15:0]               base;
    logic signed [17:0]        scale_sum;
    logic [CHAN_W-1:0]         colour_ch;
    logic [CHAN_W+15:0]        chan_prod;
    logic [PERIOD_W-1:0]       period_eff;

    assign idx_full  = MUL_W'(phase_reg) * MUL_W'(WAVE_TABLE_DEPTH);
    assign wave_idx  = idx_full[PHASE_BITS +: IDX_W];
    assign span      = $signed({1'b0, ceil_reg}) - $signed({1'b0, floor_reg});
    assign span_wave = span * $signed({1'b0, wave_reg});
    assign base      = {floor_reg, 8'h00} - {8'h00, floor_reg};
    assign scale_sum = $signed({2'b00, base}) + span_wave;
    assign chan_prod = colour_ch * scale_reg;
    assign period_eff = (period_reg == '0) ? PERIOD_W'(1) : period_reg;

    always_comb
    begin
        unique case (ch_reg)
            2'd0:    colour_ch = colour_reg[23:16];
            2'd1:    colour_ch = colour_reg[15:8];
            default: colour_ch = colour_reg[7:0];
        endcase
    end

    always_comb
    begin
        if (fsm_reg == FS_MUL)
        begin
            div_rem_init = chan_prod[CHAN_W+15:CHAN_W];
            div_dividend = {chan_prod[CHAN_W-1:0], {(DVD_W-CHAN_W){1'b0}}};
            div_divisor  = LEVEL_DIVISOR;
        end
        else
        begin
            div_rem_init = '0;
            div_dividend = {request.delta_ms, {PHASE_BITS{1'b0}}};
            div_divisor  = {{(DIV_DVS_W-PERIOD_W){1'b0}}, period_eff};
        end
    end

    // sequencer
    always_comb
    begin
        fsm_next        = fsm_reg;
        light_mode_next = light_mode_reg;
        colour_next     = colour_reg;
        phase_next      = phase_reg;
        period_next     = period_reg;
        scan_found_next = scan_found_reg;
        scan_rank_next  = scan_rank_reg;
        scan_state_next = scan_state_reg;
        scan_agent_next = scan_agent_reg;
        wave_next       = wave_reg;
        scale_next      = scale_reg;
        ch_next         = ch_reg;
        lvl_next        = lvl_reg;
        out_valid_next  = out_valid_reg && !duty.ready;
        out_red_next    = out_red_reg;
        out_green_next  = out_green_reg;
        out_blue_next   = out_blue_reg;
        div_ctl         = '0;

        unique case (fsm_reg)
            FS_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_mode_t'(request.mode))
                        REQ_TICK:
                        begin
                            if (light_mode_reg == LM_STEADY)
                            begin
                                wave_next = FULL_SCALE;
                                fsm_next  = FS_SCALE;
                            end
                            else if (light_mode_reg != LM_OFF)
                            begin
                                div_ctl.start = 1'b1;
                                div_ctl.iters = DIV_CNT_W'(DVD_W);
                                fsm_next      = FS_PHASE;
                            end
                        end
                        REQ_SESSION:
                        begin
                            if (take)
                            begin
                                scan_found_next = 1'b1;
                                scan_rank_next  = rank_new;
                                scan_state_next = request.state_code;
                                scan_agent_next = request.agent;
                            end
                            if (request.last_session)
                            begin
                                if (win_mode != light_mode_reg || win_colour != colour_reg)
                                begin
                                    phase_next = '0;
                                end
                                light_mode_next = win_mode;
                                colour_next     = win_colour;
                                period_next     = win_period;
                                scan_found_next = 1'b0;
                                scan_rank_next  = '0;
                                scan_state_next = '0;
                                scan_agent_next = '0;
                                if (win_mode == LM_OFF)
                                begin
                                    lvl_next = '{FULL_SCALE, FULL_SCALE, FULL_SCALE};
                                    fsm_next = FS_OUT;
                                end
                            end
                        end
                        REQ_DISCONNECT:
                        begin
                            scan_found_next = 1'b0;
                            scan_rank_next  = '0;
                            scan_state_next = '0;
                            scan_agent_next = '0;
                            light_mode_next = LM_OFF;
                            lvl_next        = '{FULL_SCALE, FULL_SCALE, FULL_SCALE};
                            fsm_next        = FS_OUT;
                        end
                        default: ;
                    endcase
                end
            end
            FS_PHASE:
            begin
                if (div_stat.done)
                begin
                    phase_next = phase_reg + div_q[PHASE_BITS-1:0];
                    fsm_next   = FS_WAVE;
                end
            end
            FS_WAVE:
            begin
                wave_next = wave_rom[wave_idx];
                fsm_next  = FS_SCALE;
            end
            FS_SCALE:
            begin
                scale_next = scale_sum[17] ? 16'd0 : scale_sum[15:0];
                ch_next    = 2'd0;
                fsm_next   = FS_MUL;
            end
            FS_MUL:
            begin
                div_ctl.start = 1'b1;
                div_ctl.iters = DIV_CNT_W'(CHAN_W);
                fsm_next      = FS_LEVEL;
            end
            FS_LEVEL:
            begin
                if (div_stat.done)
                begin
                    lvl_next[ch_reg] = FULL_SCALE - div_q[CHAN_W-1:0];
                    if (ch_reg == 2'd2)
                    begin
                        fsm_next = FS_OUT;
                    end
                    else
                    begin
                        ch_next  = ch_reg + 2'd1;
                        fsm_next = FS_MUL;
                    end
                end
            end
            FS_OUT:
            begin
                if (!out_valid_reg || duty.ready)
                begin
                    out_valid_next = 1'b1;
                    out_red_next   = lvl_reg[0];
                    out_green_next = lvl_reg[1];
                    out_blue_next  = lvl_reg[2];
                    fsm_next       = FS_IDLE;
                end
            end
            default:
            begin
                fsm_next = FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg        <= FS_IDLE;
            light_mode_reg <= LM_OFF;
            colour_reg     <= '0;
            phase_reg      <= '0;
            period_reg     <= '0;
            scan_found_reg <= 1'b0;
            scan_rank_reg  <= '0;
            scan_state_reg <= '0;
            scan_agent_reg <= '0;
            ch_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            fsm_reg        <= fsm_next;
            light_mode_reg <= light_mode_next;
            colour_reg     <= colour_next;
            phase_reg      <= phase_next;
            period_reg     <= period_next;
            scan_found_reg <= scan_found_next;
            scan_rank_reg  <= scan_rank_next;
            scan_state_reg <= scan_state_next;
            scan_agent_reg <= scan_agent_next;
            ch_reg         <= ch_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wave_reg      <= wave_next;
        scale_reg     <= scale_next;
        lvl_reg       <= lvl_next;
        out_red_reg   <= out_red_next;
        out_green_reg <= out_green_next;
        out_blue_reg  <= out_blue_next;
    end

    assign request.ready   = (fsm_reg == FS_IDLE);
    assign duty.valid      = out_valid_reg;
    assign duty.duty_red   = out_red_reg;
    assign duty.duty_green = out_green_reg;
    assign duty.duty_blue  = out_blue_reg;

    `SLBE_ASSERT_SAME(a_steady_fixed, light_mode_reg == LM_STEADY,
                      period_reg == '0 && colour_reg == COLOUR_DONE)
    `SLBE_ASSERT_SAME(a_scan_clear, !scan_found_reg,
                      scan_rank_reg == '0 && scan_state_reg == '0 && scan_agent_reg == '0)
    `SLBE_ASSERT_SAME(a_level_div_live, fsm_reg == FS_LEVEL, div_stat.busy || div_stat.done)

endmodule

`default_nettype wire
